FILE: design/mhpm_pkg.sv
// ----------------------------------------------------------------------------
// mhpm_pkg
// Shared widths, constants, types and helper functions of the hypertile
// point map pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpm_pkg;

  // fraction bits of coordinates, radius and weight
  localparam int COORD_FRAC_BITS = 16;

  // signed width of c and d before normalization
  localparam int CD_W  = ((2 * COORD_FRAC_BITS > 52) ? 2 * COORD_FRAC_BITS : 52) + 2;
  // largest normalizing shift and its width
  localparam int SMAX  = CD_W - 31;
  localparam int S_W   = $clog2(SMAX + 1);
  // smallest exponent of the component scale and the divisor pre-shift
  localparam int EMIN  = COORD_FRAC_BITS - SMAX;
  localparam int DSH   = (EMIN < 0) ? -EMIN : 0;
  localparam int SH_W  = $clog2(COORD_FRAC_BITS + DSH + 1);
  // divider operand widths
  localparam int DEN_W = 61;
  localparam int D2_W  = DEN_W + DSH;
  localparam int N_W   = 94;
  localparam int N2_W  = N_W + COORD_FRAC_BITS + DSH;
  localparam int Q_W   = 32;

  // constant one in c, with twice the fraction bits
  localparam logic signed [CD_W-1:0] C_ONE = CD_W'(1) << (2 * COORD_FRAC_BITS);

  // trig constants, q30
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [29:0] HALF_Q30    = 30'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // reciprocals for exact truncating division of values below 2^30
  localparam int SH_72 = 37;
  localparam int SH_42 = 36;
  localparam int SH_20 = 35;
  localparam int SH_6  = 33;
  localparam int SH_90 = 37;
  localparam int SH_56 = 36;
  localparam int SH_30 = 35;
  localparam int SH_12 = 34;
  localparam logic [30:0] RCP_72 = 31'(((64'd1 << SH_72) + 64'd71) / 64'd72);
  localparam logic [30:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [30:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [30:0] RCP_90 = 31'(((64'd1 << SH_90) + 64'd89) / 64'd90);
  localparam logic [30:0] RCP_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [30:0] RCP_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [30:0] RCP_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  // saturation values
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // register indexes
  localparam logic [1:0] CFG_SECTOR = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_WEIGHT = 2'd2;

  // register reset values
  localparam logic [15:0] SECTOR_RST = 16'd21845;
  localparam logic [20:0] RADIUS_RST = 21'd65536;
  localparam logic [31:0] WEIGHT_RST = 32'd65536;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
    point_t             pt;
  } trig_t;

  typedef struct packed {
    logic signed [63:0] numx;
    logic signed [63:0] numy;
    logic [DEN_W-1:0]   den;
    logic [S_W-1:0]     s;
  } map_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic               sat;
    logic               zero;
  } div_res_t;

  // q30 product, truncated
  function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] pr;
    pr = 61'(a) * 61'(b);
    return pr[59:30];
  endfunction

  // truncating division by a constant through its reciprocal
  function automatic logic [29:0] div_rcp(input logic [29:0] a, input logic [30:0] m,
                                          input int sh);
    logic [60:0] pr;
    pr = 61'(a) * 61'(m);
    return 30'(pr >> sh);
  endfunction

endpackage

`default_nettype wire

FILE: design/mhpm_sincos.sv
// ----------------------------------------------------------------------------
// mhpm_sincos
// Pipelined angle and q30 sine / cosine: octant fold, truncating Horner
// polynomials.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpm_sincos (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_vld,
  input  wire logic [15:0]    rand_fraction,
  input  wire logic [15:0]    sector,
  input  wire mhpm_pkg::point_t pt_in,
  output logic                out_vld,
  output mhpm_pkg::trig_t     trig
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  logic [13:1] vld;
  mhpm_pkg::point_t pt [1:12];
  logic [31:0] u1;
  logic [1:0]  quad [2:12];
  logic        fold [2:12];
  logic [29:0] f2;
  logic [29:0] phi [3:11];
  logic [29:0] p [4:11];
  logic [30:0] ts5, tc5, ts7, tc7, ts9, tc9, ts11, tc11;
  logic [29:0] ms6, mc6, ms8, mc8, ms10, mc10, s12, mc12;

  logic [29:0] f_raw;
  logic        fold_c;
  logic [30:0] c_val, s_val, sw_s, sw_c;
  logic signed [31:0] sn_c, cs_c;

  // octant fold
  always_comb begin
    f_raw  = u1[29:0];
    fold_c = f_raw > mhpm_pkg::HALF_Q30;
  end

  // final cosine term, swap and quadrant
  always_comb begin
    c_val = mhpm_pkg::ONE_Q30 - {2'b0, mc12[29:1]};
    s_val = {1'b0, s12};
    sw_s  = fold[12] ? c_val : s_val;
    sw_c  = fold[12] ? s_val : c_val;
    case (quad[12])
      QUAD_0: begin
        sn_c = {1'b0, sw_s};
        cs_c = {1'b0, sw_c};
      end
      QUAD_1: begin
        sn_c = {1'b0, sw_c};
        cs_c = -{1'b0, sw_s};
      end
      QUAD_2: begin
        sn_c = -{1'b0, sw_s};
        cs_c = -{1'b0, sw_c};
      end
      default: begin
        sn_c = -{1'b0, sw_c};
        cs_c = {1'b0, sw_s};
      end
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[12:1], in_vld};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      pt[1] <= pt_in;
      for (int k = 2; k <= 12; k++) pt[k] <= pt[k-1];
      u1 <= 32'(rand_fraction) * 32'(sector);
      quad[2] <= u1[31:30];
      fold[2] <= fold_c;
      for (int k = 3; k <= 12; k++) begin
        quad[k] <= quad[k-1];
        fold[k] <= fold[k-1];
      end
      f2 <= fold_c ? 30'(mhpm_pkg::ONE_Q30 - {1'b0, f_raw}) : f_raw;
      phi[3] <= mhpm_pkg::mul_q30(f2, mhpm_pkg::HALF_PI_Q30);
      for (int k = 4; k <= 11; k++) phi[k] <= phi[k-1];
      p[4] <= mhpm_pkg::mul_q30(phi[3], {1'b0, phi[3]});
      for (int k = 5; k <= 11; k++) p[k] <= p[k-1];
      // horner, innermost terms
      ts5  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(p[4], mhpm_pkg::RCP_72,
                                                            mhpm_pkg::SH_72)};
      tc5  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(p[4], mhpm_pkg::RCP_90,
                                                            mhpm_pkg::SH_90)};
      ms6  <= mhpm_pkg::mul_q30(p[5], ts5);
      mc6  <= mhpm_pkg::mul_q30(p[5], tc5);
      ts7  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(ms6, mhpm_pkg::RCP_42,
                                                            mhpm_pkg::SH_42)};
      tc7  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(mc6, mhpm_pkg::RCP_56,
                                                            mhpm_pkg::SH_56)};
      ms8  <= mhpm_pkg::mul_q30(p[7], ts7);
      mc8  <= mhpm_pkg::mul_q30(p[7], tc7);
      ts9  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(ms8, mhpm_pkg::RCP_20,
                                                            mhpm_pkg::SH_20)};
      tc9  <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(mc8, mhpm_pkg::RCP_30,
                                                            mhpm_pkg::SH_30)};
      ms10 <= mhpm_pkg::mul_q30(p[9], ts9);
      mc10 <= mhpm_pkg::mul_q30(p[9], tc9);
      ts11 <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(ms10, mhpm_pkg::RCP_6,
                                                            mhpm_pkg::SH_6)};
      tc11 <= mhpm_pkg::ONE_Q30 - {1'b0, mhpm_pkg::div_rcp(mc10, mhpm_pkg::RCP_12,
                                                            mhpm_pkg::SH_12)};
      s12  <= mhpm_pkg::mul_q30(phi[11], ts11);
      mc12 <= mhpm_pkg::mul_q30(p[11], tc11);
      trig.sn <= sn_c;
      trig.cs <= cs_c;
      trig.pt <= pt[12];
    end
  end

  assign out_vld = vld[13];

endmodule

`default_nettype wire

FILE: design/mhpm_geom.sv
// ----------------------------------------------------------------------------
// mhpm_geom
// Offset from radius and angle, map terms a, b, c, d, normalization of c
// and d, denominator and the two numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpm_geom (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_vld,
  input  wire logic [20:0]     radius,
  input  wire mhpm_pkg::trig_t trig,
  output logic                 out_vld,
  output mhpm_pkg::map_t       map
);

  localparam int CD_W = mhpm_pkg::CD_W;
  localparam int S_W  = mhpm_pkg::S_W;

  logic [8:1] vld;

  // stage 1
  mhpm_pkg::point_t pt1;
  logic signed [21:0] re1, im1;
  // stage 2
  logic signed [32:0] a2, b2;
  logic signed [53:0] prx2, piy2, pry2, pix2;
  // stage 3
  logic signed [32:0] a3, b3;
  logic signed [CD_W-1:0] c3, d3;
  // stage 4
  logic signed [32:0] a4, b4;
  logic [CD_W-2:0] mc4, md4, or4;
  logic sc4, sd4;
  // stage 5
  logic signed [32:0] a5, b5;
  logic [CD_W-2:0] mc5, md5;
  logic sc5, sd5;
  logic [S_W-1:0] s5;
  // stage 6
  logic signed [32:0] a6, b6;
  logic [29:0] cm6, dm6;
  logic signed [30:0] cn6, dn6;
  logic [S_W-1:0] s6;
  // stage 7
  logic [59:0] sqc7, sqd7;
  logic signed [63:0] p1_7, p2_7, p3_7, p4_7;
  logic [S_W-1:0] s7;

  logic [30:0] mcs, msn;
  logic [51:0] pr_re, pr_im;
  logic [20:0] m_re, m_im;
  logic [S_W-1:0] s_enc;
  logic [CD_W-2:0] shc, shd;

  // radius times trig, rounded half away from zero
  always_comb begin
    mcs   = trig.cs[31] ? 31'(-trig.cs) : trig.cs[30:0];
    msn   = trig.sn[31] ? 31'(-trig.sn) : trig.sn[30:0];
    pr_re = 52'(radius) * 52'(mcs);
    pr_im = 52'(radius) * 52'(msn);
    m_re  = 21'((pr_re + 52'(1 << 29)) >> 30);
    m_im  = 21'((pr_im + 52'(1 << 29)) >> 30);
  end

  // normalizing shift from the top set bit
  always_comb begin
    s_enc = '0;
    for (int i = 30; i <= CD_W - 2; i++) begin
      if (or4[i]) s_enc = S_W'(i - 29);
    end
  end

  always_comb begin
    shc = mc5 >> s5;
    shd = md5 >> s5;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // offset
      pt1 <= trig.pt;
      re1 <= trig.cs[31] ? -$signed({1'b0, m_re}) : $signed({1'b0, m_re});
      im1 <= trig.sn[31] ? -$signed({1'b0, m_im}) : $signed({1'b0, m_im});
      // a, b and cross products
      a2   <= 33'(pt1.x) + 33'(re1);
      b2   <= 33'(pt1.y) - 33'(im1);
      prx2 <= re1 * pt1.x;
      piy2 <= im1 * pt1.y;
      pry2 <= re1 * pt1.y;
      pix2 <= im1 * pt1.x;
      // c and d
      a3 <= a2;
      b3 <= b2;
      c3 <= CD_W'(prx2) - CD_W'(piy2) + mhpm_pkg::C_ONE;
      d3 <= CD_W'(pry2) + CD_W'(pix2);
      // magnitudes
      a4  <= a3;
      b4  <= b3;
      mc4 <= c3[CD_W-1] ? (CD_W-1)'(-c3) : c3[CD_W-2:0];
      md4 <= d3[CD_W-1] ? (CD_W-1)'(-d3) : d3[CD_W-2:0];
      or4 <= (c3[CD_W-1] ? (CD_W-1)'(-c3) : c3[CD_W-2:0])
           | (d3[CD_W-1] ? (CD_W-1)'(-d3) : d3[CD_W-2:0]);
      sc4 <= c3[CD_W-1];
      sd4 <= d3[CD_W-1];
      // shift amount
      a5  <= a4;
      b5  <= b4;
      mc5 <= mc4;
      md5 <= md4;
      sc5 <= sc4;
      sd5 <= sd4;
      s5  <= s_enc;
      // normalized c, d
      a6  <= a5;
      b6  <= b5;
      cm6 <= shc[29:0];
      dm6 <= shd[29:0];
      cn6 <= sc5 ? -$signed({1'b0, shc[29:0]}) : $signed({1'b0, shc[29:0]});
      dn6 <= sd5 ? -$signed({1'b0, shd[29:0]}) : $signed({1'b0, shd[29:0]});
      s6  <= s5;
      // squares and numerator products
      sqc7 <= 60'(cm6) * 60'(cm6);
      sqd7 <= 60'(dm6) * 60'(dm6);
      p1_7 <= a6 * cn6;
      p2_7 <= b6 * dn6;
      p3_7 <= b6 * cn6;
      p4_7 <= a6 * dn6;
      s7   <= s6;
      // sums
      map.den  <= mhpm_pkg::DEN_W'(sqc7) + mhpm_pkg::DEN_W'(sqd7);
      map.numx <= p1_7 + p2_7;
      map.numy <= p3_7 - p4_7;
      map.s    <= s7;
    end
  end

  assign out_vld = vld[8];

endmodule

`default_nettype wire

FILE: design/mhpm_divider.sv
// ----------------------------------------------------------------------------
// mhpm_divider
// Weighted numerators over the denominator for both components: split
// products, alignment, overflow check and a 32-step restoring divider,
// one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpm_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire logic           in_vld,
  input  wire logic [31:0]    weight,
  input  wire mhpm_pkg::map_t map,
  output logic                out_vld,
  output mhpm_pkg::div_res_t  res
);

  localparam int D2_W  = mhpm_pkg::D2_W;
  localparam int N2_W  = mhpm_pkg::N2_W;
  localparam int N_W   = mhpm_pkg::N_W;
  localparam int SH_W  = mhpm_pkg::SH_W;
  localparam int Q_W   = mhpm_pkg::Q_W;
  localparam int STEPS = Q_W;
  localparam int LAT   = 4 + STEPS + 1;
  localparam logic [SH_W-1:0] SH_TOP = SH_W'(mhpm_pkg::COORD_FRAC_BITS + mhpm_pkg::DSH);

  logic [LAT:1] vld;

  // shared sideband
  logic [mhpm_pkg::DEN_W-1:0] den1, den2, den3;
  logic [SH_W-1:0] sh2;
  logic [mhpm_pkg::S_W-1:0] s1;
  logic [D2_W-1:0] dd [0:STEPS];
  logic zero [1:LAT];
  logic [31:0] wm;
  logic signed [63:0] num_in [2];

  assign wm        = weight[31] ? 32'(-weight) : weight;
  assign num_in[0] = map.numx;
  assign num_in[1] = map.numy;

  logic signed [31:0] lane_r [2];
  logic               lane_sat [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_vld};
    end
  end

  // sideband pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      den1    <= map.den;
      s1      <= map.s;
      zero[1] <= map.den == '0;
      den2    <= den1;
      sh2     <= SH_TOP - SH_W'(s1);
      den3    <= den2;
      dd[0]   <= D2_W'(den3) << mhpm_pkg::DSH;
      for (int k = 2; k <= LAT; k++) zero[k] <= zero[k-1];
      for (int k = 1; k <= STEPS; k++) dd[k] <= dd[k-1];
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic        neg [1:STEPS+4];
    logic [63:0] lo1;
    logic [62:0] hi1;
    logic [N_W-1:0] n2;
    logic [N2_W-1:0] n3;
    logic        big [0:STEPS];
    logic [D2_W-1:0] rem [0:STEPS];
    logic [31:0] low [0:STEPS];
    logic [Q_W-1:0] quo [0:STEPS];
    logic [62:0] nm;
    logic [31:0] limit, val;
    logic        sat_c;

    assign nm = num_in[ln][63] ? 63'(-num_in[ln]) : num_in[ln][62:0];

    // saturation and sign
    always_comb begin
      limit = neg[STEPS+4] ? mhpm_pkg::SAT_NEG : mhpm_pkg::SAT_POS;
      sat_c = big[STEPS] || (quo[STEPS] > limit);
      val   = sat_c ? limit : quo[STEPS];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        // split product weight times numerator
        neg[1] <= weight[31] ^ num_in[ln][63];
        lo1    <= 64'(wm) * 64'(nm[31:0]);
        hi1    <= 63'(wm) * 63'(nm[62:32]);
        for (int k = 2; k <= STEPS + 4; k++) neg[k] <= neg[k-1];
        n2 <= N_W'({hi1, 32'b0}) + N_W'(lo1);
        n3 <= N2_W'(n2) << sh2;
        // quotient of 2^32 or more saturates
        big[0] <= n3[N2_W-1:32] >= (N2_W-32)'(D2_W'(den3) << mhpm_pkg::DSH);
        rem[0] <= n3[32+D2_W-1:32];
        low[0] <= n3[31:0];
        quo[0] <= '0;
        for (int k = 1; k <= STEPS; k++) begin
          big[k] <= big[k-1];
          low[k] <= {low[k-1][30:0], 1'b0};
          if ({rem[k-1], low[k-1][31]} >= {1'b0, dd[k-1]}) begin
            rem[k] <= D2_W'({rem[k-1], low[k-1][31]} - {1'b0, dd[k-1]});
            quo[k] <= {quo[k-1][Q_W-2:0], 1'b1};
          end else begin
            rem[k] <= {rem[k-1][D2_W-2:0], low[k-1][31]};
            quo[k] <= {quo[k-1][Q_W-2:0], 1'b0};
          end
        end
        lane_r[ln]   <= neg[STEPS+4] ? -$signed(val) : $signed(val);
        lane_sat[ln] <= sat_c;
      end
    end
  end

  always_comb begin
    res.rx   = lane_r[0];
    res.ry   = lane_r[1];
    res.sat  = lane_sat[0] | lane_sat[1];
    res.zero = zero[LAT];
  end

  assign out_vld = vld[LAT];

endmodule

`default_nettype wire

FILE: design/mobius_hypertile_point_map.sv
// ----------------------------------------------------------------------------
// mobius_hypertile_point_map
// Hypertile flame variation: rotated offset, Moebius map and weight, giving
// the displacement that the caller adds to its accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   point channel (point_valid / point_ready): x_in, y_in, rand_fraction.
//   disp channel (disp_valid / disp_ready): dx_out, dy_out, overflow.
//   cfg_we / cfg_index / cfg_data write sector_fraction (0), tile_radius (1)
//   and weight (2); other indexes are ignored. Write only while idle.
// Timing:
//   one transaction per cycle in and out unless disp_ready stalls; from accept
//   to disp_valid: 13 sincos stages, 8 map stages, 37 divider stages (restoring
//   steps give one quotient bit per stage) and one output register.
// Flow control:
//   the whole pipeline advances together; point_ready is low only while a
//   result sits in the output register and disp_ready is low. Nothing is
//   lost or repeated across a stall.
// Reset:
//   synchronous rst empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mobius_hypertile_point_map (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               point_valid,
  output logic                    point_ready,
  input  wire logic signed [31:0] x_in,
  input  wire logic signed [31:0] y_in,
  input  wire logic [15:0]        rand_fraction,
  output logic                    disp_valid,
  input  wire logic               disp_ready,
  output logic signed [31:0]      dx_out,
  output logic signed [31:0]      dy_out,
  output logic                    overflow,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [15:0] sector;
  logic [20:0] radius;
  logic [31:0] weight;
  logic        adv;

  mhpm_pkg::point_t   pt_in;
  mhpm_pkg::trig_t    trig;
  mhpm_pkg::map_t     map;
  mhpm_pkg::div_res_t res;
  logic trig_vld, map_vld, res_vld;

  assign adv         = !disp_valid || disp_ready;
  assign point_ready = adv;
  assign pt_in.x     = x_in;
  assign pt_in.y     = y_in;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sector <= mhpm_pkg::SECTOR_RST;
      radius <= mhpm_pkg::RADIUS_RST;
      weight <= mhpm_pkg::WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mhpm_pkg::CFG_SECTOR: sector <= cfg_data[15:0];
        mhpm_pkg::CFG_RADIUS: radius <= cfg_data[20:0];
        mhpm_pkg::CFG_WEIGHT: weight <= cfg_data;
        default: ;
      endcase
    end
  end

  mhpm_sincos u_sincos (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_vld        (point_valid),
    .rand_fraction (rand_fraction),
    .sector        (sector),
    .pt_in         (pt_in),
    .out_vld       (trig_vld),
    .trig          (trig)
  );

  mhpm_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (trig_vld),
    .radius  (radius),
    .trig    (trig),
    .out_vld (map_vld),
    .map     (map)
  );

  mhpm_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (map_vld),
    .weight  (weight),
    .map     (map),
    .out_vld (res_vld),
    .res     (res)
  );

  // output register, zero denominator saturates both components
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_valid <= 1'b0;
    end else if (adv) begin
      disp_valid <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (res.zero) begin
        dx_out   <= weight[31] ? mhpm_pkg::SAT_NEG : mhpm_pkg::SAT_POS;
        dy_out   <= weight[31] ? mhpm_pkg::SAT_NEG : mhpm_pkg::SAT_POS;
        overflow <= 1'b1;
      end else begin
        dx_out   <= res.rx;
        dy_out   <= res.ry;
        overflow <= res.sat;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mhpm_checker.sv
// ----------------------------------------------------------------------------
// mhpm_checker
// Port-level checks of the hypertile point map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               point_valid,
  input wire logic               point_ready,
  input wire logic signed [31:0] x_in,
  input wire logic signed [31:0] y_in,
  input wire logic [15:0]        rand_fraction,
  input wire logic               disp_valid,
  input wire logic               disp_ready,
  input wire logic signed [31:0] dx_out,
  input wire logic signed [31:0] dy_out,
  input wire logic               overflow,
  input wire logic               cfg_we,
  input wire logic [1:0]         cfg_index,
  input wire logic [31:0]        cfg_data
);

  // a stalled result holds its transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    disp_valid && !disp_ready |=> disp_valid && $stable(dx_out) && $stable(dy_out)
      && $stable(overflow))
    else $error("stalled result changed");

  // a waiting point holds its transaction
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    point_valid && !point_ready |=> point_valid && $stable(x_in) && $stable(y_in)
      && $stable(rand_fraction))
    else $error("waiting point changed");

  // input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    point_ready == (!disp_valid || disp_ready))
    else $error("point_ready does not follow output stall");

  // register writes only while both channels are quiet
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !point_valid && !disp_valid && !$isunknown({cfg_index, cfg_data}))
    else $error("register write while busy");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !disp_valid)
    else $error("result present after reset");

endmodule

bind mobius_hypertile_point_map mhpm_checker u_checker (.*);

`default_nettype wire

FILE: dv/mobius_hypertile_point_map_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mobius_hypertile_point_map_tb
// Streams points through the hypertile point map under several register
// settings, with random gaps on both channels and one long output stall, and
// checks every displacement against a bit-true model kept in the bench or a typed value.
// ----------------------------------------------------------------------------

module mobius_hypertile_point_map_tb;

  localparam int LATENCY    = 59;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [63:0] HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30     = 64'd1 << 30;
  // index with no register behind it
  localparam logic [1:0]  CFG_SPARE = 2'd3;

  typedef struct {
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic               ov;
  } disp_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        rf;
    bit                 typed;
    disp_t              want;
  } point_row_t;

  logic               clk;
  logic               rst;
  logic               point_valid;
  logic               point_ready;
  logic signed [31:0] x_in;
  logic signed [31:0] y_in;
  logic [15:0]        rand_fraction;
  logic               disp_valid;
  logic               disp_ready;
  logic signed [31:0] dx_out;
  logic signed [31:0] dy_out;
  logic               overflow;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  // register copies used by the displacement model
  logic [15:0]        sector_q;
  logic [20:0]        radius_q;
  logic signed [31:0] weight_q;

  point_row_t point_fifo[$];
  disp_t      disp_expected[$];
  int         errors;
  int         points_sent;
  int         disps_checked;
  int         idle_cycles;
  int         stall_request;
  bit         calm;

  mobius_hypertile_point_map dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_ready(point_ready),
    .x_in(x_in), .y_in(y_in), .rand_fraction(rand_fraction),
    .disp_valid(disp_valid), .disp_ready(disp_ready),
    .dx_out(dx_out), .dy_out(dy_out), .overflow(overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // one component: weight * num * 2^e / den, truncated, saturated
  function automatic logic [31:0] disp_component(longint w, longint num, int e,
                                                 logic [63:0] den, inout bit sat);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] lim;
    bit           neg;
    neg = (w < 0) != (num < 0);
    n = {64'd0, mag(w)} * {64'd0, mag(num)};
    d = {64'd0, den};
    if (e >= 0) n = n << e;
    else d = d << (-e);
    q = n / d;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // bit-true displacement for one point under the current registers
  function automatic disp_t map_point(logic signed [31:0] x, logic signed [31:0] y,
                                      logic [15:0] rf);
    logic [31:0] u;
    logic [63:0] f, phi, p, t, sv, cv, tmp, mc, md, mx, den;
    bit          fold, sat;
    longint      sn, cs, re, im, a, b, c, d, cn, dn, w;
    int          s;
    disp_t       r;
    u = 32'(rf) * 32'(sector_q);
    f = {34'd0, u[29:0]};
    fold = f > (64'd1 << 29);
    if (fold) f = Q30 - f;
    phi = (f * HALF_PI) >> 30;
    p = (phi * phi) >> 30;
    t = Q30 - p / 72;
    t = Q30 - ((p * t) >> 30) / 42;
    t = Q30 - ((p * t) >> 30) / 20;
    t = Q30 - ((p * t) >> 30) / 6;
    sv = (phi * t) >> 30;
    t = Q30 - p / 90;
    t = Q30 - ((p * t) >> 30) / 56;
    t = Q30 - ((p * t) >> 30) / 30;
    t = Q30 - ((p * t) >> 30) / 12;
    cv = Q30 - ((p * t) >> 30) / 2;
    if (fold) begin
      tmp = sv; sv = cv; cv = tmp;
    end
    case (u[31:30])
      2'd0:    begin sn = sv;  cs = cv;  end
      2'd1:    begin sn = cv;  cs = -sv; end
      2'd2:    begin sn = -sv; cs = -cv; end
      default: begin sn = -cv; cs = sv;  end
    endcase
    // offset at radius, rounded half away from zero
    re = longint'((64'(radius_q) * mag(cs) + (64'd1 << 29)) >> 30);
    if (cs < 0) re = -re;
    im = longint'((64'(radius_q) * mag(sn) + (64'd1 << 29)) >> 30);
    if (sn < 0) im = -im;
    a = longint'(x) + re;
    b = longint'(y) - im;
    c = re * longint'(x) - im * longint'(y)
      + (longint'(1) << (2 * mhpm_pkg::COORD_FRAC_BITS));
    d = re * longint'(y) + im * longint'(x);
    // normalize c and d below 2^30
    mc = mag(c);
    md = mag(d);
    mx = mc > md ? mc : md;
    s = 0;
    while ((mx >> s) >= Q30) s++;
    cn = longint'(mc >> s); if (c < 0) cn = -cn;
    dn = longint'(md >> s); if (d < 0) dn = -dn;
    den = 64'(cn * cn) + 64'(dn * dn);
    w = longint'(weight_q);
    sat = 1'b0;
    if (den == 0) begin
      r.dx = (w < 0) ? mhpm_pkg::SAT_NEG : mhpm_pkg::SAT_POS;
      r.dy = r.dx;
      sat = 1'b1;
    end else begin
      r.dx = disp_component(w, a * cn + b * dn, mhpm_pkg::COORD_FRAC_BITS - s, den, sat);
      r.dy = disp_component(w, b * cn - a * dn, mhpm_pkg::COORD_FRAC_BITS - s, den, sat);
    end
    r.ov = sat;
    return r;
  endfunction

  // register write, mirrored into the model copy
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      mhpm_pkg::CFG_SECTOR: sector_q = data[15:0];
      mhpm_pkg::CFG_RADIUS: radius_q = data[20:0];
      mhpm_pkg::CFG_WEIGHT: weight_q = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] sec, logic [20:0] rad, logic [31:0] wt);
    write_reg(mhpm_pkg::CFG_SECTOR, {16'd0, sec});
    write_reg(mhpm_pkg::CFG_RADIUS, {11'd0, rad});
    write_reg(mhpm_pkg::CFG_WEIGHT, wt);
  endtask

  // block until every queued point is in and every displacement is out
  task automatic drain();
    while (point_fifo.size() != 0 || disp_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic point_row_t plain_row(logic [31:0] x, logic [31:0] y, logic [15:0] rf);
    point_row_t r;
    r.x = x; r.y = y; r.rf = rf; r.typed = 1'b0;
    r.want = '{dx: 32'd0, dy: 32'd0, ov: 1'b0};
    return r;
  endfunction

  function automatic point_row_t typed_row(logic [31:0] x, logic [31:0] y, logic [15:0] rf,
                                           logic [31:0] dx, logic [31:0] dy, logic ov);
    point_row_t r;
    r = plain_row(x, y, rf);
    r.typed = 1'b1;
    r.want = '{dx: dx, dy: dy, ov: ov};
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2:    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      3:    return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic point_row_t rand_row();
    point_row_t  r;
    logic [15:0] rf;
    rf = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                     : 16'($urandom);
    r = plain_row(rand_coord(), rand_coord(), rf);
    // near the pole: zero angle, x close to -1/r
    if (radius_q != 0 && $urandom_range(0, 7) == 0) begin
      r.rf = 16'd0;
      r.x  = 32'(-longint'((64'd1 << 32) / 64'(radius_q)))
           + 32'($signed($urandom_range(0, 4)) - 2);
      r.y  = 32'($signed($urandom_range(0, 4)) - 2);
    end
    return r;
  endfunction

  // point sender: random gap per transaction, valid held until accepted
  initial begin
    int         gap;
    point_row_t row;
    point_valid   <= 1'b0;
    x_in          <= '0;
    y_in          <= '0;
    rand_fraction <= '0;
    @(negedge rst);
    forever begin
      if (point_fifo.size() == 0) begin
        point_valid <= 1'b0;
        @(posedge clk);
      end else begin
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          point_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        row = point_fifo[0];
        x_in          <= row.x;
        y_in          <= row.y;
        rand_fraction <= row.rf;
        point_valid   <= 1'b1;
        @(posedge clk);
        while (!point_ready) @(posedge clk);
        void'(point_fifo.pop_front());
        disp_expected.push_back(row.typed ? row.want : map_point(row.x, row.y, row.rf));
        points_sent++;
      end
    end
  end

  // displacement receiver: random stall per transaction plus long hold-offs
  initial begin
    int hold;
    int wait_cnt;
    bit rdy;
    hold = 0;
    wait_cnt = 0;
    disp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        hold = stall_request;
        stall_request = 0;
      end
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else if (disp_valid && disp_ready) begin
        wait_cnt = calm ? 0 : $urandom_range(0, 8);
        rdy = (wait_cnt == 0);
      end else if (wait_cnt > 0) begin
        wait_cnt--;
        rdy = (wait_cnt == 0);
      end else begin
        rdy = 1'b1;
      end
      disp_ready <= rdy;
    end
  end

  // displacement check against the oldest expectation
  always @(posedge clk) begin
    disp_t want;
    if (!rst && disp_valid && disp_ready) begin
      if (disp_expected.size() == 0) begin
        $error("displacement transaction with nothing expected");
        errors++;
      end else begin
        want = disp_expected.pop_front();
        if (dx_out !== want.dx) begin
          $error("dx_out expected %h actual %h", want.dx, dx_out);
          errors++;
        end
        if (dy_out !== want.dy) begin
          $error("dy_out expected %h actual %h", want.dy, dy_out);
          errors++;
        end
        if (overflow !== want.ov) begin
          $error("overflow expected %b actual %b", want.ov, overflow);
          errors++;
        end
        disps_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((point_valid && point_ready) || (disp_valid && disp_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // directed points under reset registers
  point_row_t directed[] = '{
    typed_row(32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0001_0000, 32'h0, 1'b0),
    typed_row(32'hFFFF_0000, 32'h0000_0000, 16'h0000, mhpm_pkg::SAT_POS,
              mhpm_pkg::SAT_POS, 1'b1),
    plain_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF),
    plain_row(32'h8000_0000, 32'h8000_0000, 16'h0000),
    plain_row(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000),
    plain_row(32'h7FFF_FFFF, 32'h8000_0000, 16'h0001),
    plain_row(32'h0000_0000, 32'h0000_0000, 16'hFFFF),
    plain_row(32'h0001_0000, 32'h0000_0000, 16'h4000),
    plain_row(32'h0000_0000, 32'h0001_0000, 16'hC000),
    plain_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001),
    plain_row(32'h0000_3039, 32'hFFFF_2BCF, 16'hAAAA),
    plain_row(32'hFFFF_0001, 32'h0000_0001, 16'h0000),
    plain_row(32'h0000_8000, 32'hFFFF_8000, 16'h5555),
    plain_row(32'h5555_5555, 32'hAAAA_AAAA, 16'h3C3C)
  };

  // main sequence
  initial begin
    logic [15:0] sec_tab[8] = '{16'd21845, 16'd0, 16'd65535, 16'd65535, 16'd16384,
                                16'd0, 16'd0, 16'd0};
    logic [20:0] rad_tab[8] = '{21'd65536, 21'd1048576, 21'd0, 21'd1048576, 21'd32768,
                                21'd0, 21'd0, 21'd0};
    logic [31:0] wt_tab[8]  = '{32'd65536, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                                32'd0, 32'd0, 32'd0, 32'd0};
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    errors = 0;
    points_sent = 0;
    disps_checked = 0;
    idle_cycles = 0;
    stall_request = 0;
    calm = 1'b0;
    sector_q = mhpm_pkg::SECTOR_RST;
    radius_q = mhpm_pkg::RADIUS_RST;
    weight_q = mhpm_pkg::WEIGHT_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) point_fifo.push_back(directed[i]);
    drain();

    // zero denominator with negative weight; unknown index is ignored
    write_reg(mhpm_pkg::CFG_WEIGHT, 32'hFFFF_0000);
    write_reg(CFG_SPARE, 32'h1234_5678);
    point_fifo.push_back(typed_row(32'hFFFF_0000, 32'h0, 16'h0, mhpm_pkg::SAT_NEG,
                                   mhpm_pkg::SAT_NEG, 1'b1));
    drain();

    // random phases over a range of register settings
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 5) set_regs(sec_tab[ph], rad_tab[ph], wt_tab[ph]);
      else set_regs(16'($urandom), 21'($urandom_range(0, 1048576)), $urandom);
      calm = (ph == 4);
      for (int k = 0; k < 150; k++) point_fifo.push_back(rand_row());
      if (ph == 6) begin
        repeat (20) @(posedge clk);
        stall_request = 300;
      end
      drain();
    end

    $display("covered %0d points in, %0d displacements checked over 9 register settings,",
             points_sent, disps_checked);
    $display("including saturation, zero denominator and a long output hold-off");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
